@@ rtl/slotpool_pkg.sv @@
// Shared types and constants for the slot pool with lifetime expiry.
// Used by slot_pool_with_lifetime_expiry_top and slotpool_ctrl; depends on nothing.
`default_nettype none

package slotpool_pkg;

  // Pool size. Must be a power of two and a multiple of GROUP.
  localparam int SLOTS   = 128;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int LIFE_W  = 16;

  // Allocate searches the used flags one group at a time.
  localparam int GROUP   = 8;
  localparam int GROUPS  = SLOTS / GROUP;
  localparam int GROUP_W = $clog2(GROUPS);
  localparam int GSEL_W  = $clog2(GROUP);

  localparam int OP_W    = 2;
  localparam int INDEX_W = 7;
  localparam int ST_W    = 2;
  localparam int GRANT_W = 7;
  localparam int FREED_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_TICK   = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TICK,
    S_PUT
  } state_t;

  typedef struct packed {
    op_t                 operation;
    logic [LIFE_W-1:0]   lifetime;
    logic [INDEX_W-1:0]  slot_index;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [GRANT_W-1:0]  granted_slot;
    logic [FREED_W-1:0]  freed_count;
  } rsp_t;

  // Lifetime memory write port.
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  addr;
    logic [LIFE_W-1:0]  data;
  } life_wr_t;

  // Lifetime memory read port.
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  addr;
  } life_rd_t;

endpackage

`default_nettype wire

@@ rtl/slot_pool_with_lifetime_expiry_top.sv @@
// Top level of the slot pool with lifetime expiry: sequencer, lifetime RAM
// and output register. Uses slotpool_pkg, slotpool_ctrl, slotpool_life_ram.
`default_nettype none

// Slot pool of SLOTS (128) entries, each a used flag plus a 16-bit lifetime.
// One item is worked at a time and each item returns exactly one result.
// Path from acceptance to the result in the output register:
//   delete, clear : decided as the item is accepted (used flags sit in flip-flops)
//   allocate      : the used flags are searched eight per cycle, lowest
//                   group first, until a free slot or the last group
//   tick          : every lifetime is read; those of used slots that are
//                   not zero are decremented and written back, through the one
//                   read and one write port of the lifetime RAM
// The next item is taken in the cycle after the result is loaded; the
// output register lets that happen while the previous result is still
// held under out_stall. No clearing pass is needed after reset: a tick
// reads every lifetime but acts only on slots marked used, and a used
// slot always had its lifetime written when it was allocated.
module slot_pool_with_lifetime_expiry_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire slotpool_pkg::req_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output slotpool_pkg::rsp_t      out_data
);

  import slotpool_pkg::*;

  life_wr_t           life_wr;
  life_rd_t           life_rd;
  logic [LIFE_W-1:0]  life_rd_data;
  logic               res_valid;
  logic               res_ready;
  rsp_t               res;

  logic               out_valid_r, out_valid_nxt;
  rsp_t               out_data_r, out_data_nxt;

  slotpool_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_valid),
    .req          (in_data),
    .req_stall    (in_stall),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .life_wr      (life_wr),
    .life_rd      (life_rd),
    .life_rd_data (life_rd_data)
  );

  slotpool_life_ram #(
    .DEPTH (SLOTS),
    .WIDTH (LIFE_W)
  ) u_life_ram (
    .clk     (clk),
    .wr_en   (life_wr.en),
    .wr_addr (life_wr.addr),
    .wr_data (life_wr.data),
    .rd_en   (life_rd.en),
    .rd_addr (life_rd.addr),
    .rd_data (life_rd_data)
  );

  // Output register: load when empty or being drained this cycle.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      // drop the delivered item
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/slotpool_life_ram.sv @@
// Simple dual-port RAM holding the lifetime count of each slot.
// One write and one registered read per cycle; depends on nothing.
`default_nettype none

module slotpool_life_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/slotpool_ctrl.sv @@
// Sequencer of the slot pool: used flags, group search for allocate and the
// lifetime walk for tick. Uses slotpool_pkg; drives slotpool_life_ram.
`default_nettype none

module slotpool_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     req_valid,
  input  wire slotpool_pkg::req_t       req,
  output logic                          req_stall,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output slotpool_pkg::rsp_t            res,
  output slotpool_pkg::life_wr_t        life_wr,
  output slotpool_pkg::life_rd_t        life_rd,
  input  wire logic [slotpool_pkg::LIFE_W-1:0] life_rd_data
);

  import slotpool_pkg::*;

  state_t              state_r, state_nxt;
  logic [SLOTS-1:0]    used_r, used_nxt;
  rsp_t                res_r, res_nxt;
  logic [LIFE_W-1:0]   life_r, life_nxt;
  logic [GROUP_W-1:0]  grp_r, grp_nxt;
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [SLOT_W-1:0]   pend_addr_r, pend_addr_nxt;

  logic [GROUP-1:0]    free_grp;
  logic                grp_hit;
  logic [GSEL_W-1:0]   grp_sel;
  logic [SLOT_W-1:0]   hit_slot;
  logic                issue_done;
  logic [LIFE_W-1:0]   life_dec;

  // Lowest free slot within the current group.
  always_comb begin
    free_grp = ~used_r[grp_r*GROUP +: GROUP];
    grp_hit  = |free_grp;
    grp_sel  = '0;
    for (int j = GROUP - 1; j >= 0; j--) begin
      if (free_grp[j]) begin
        grp_sel = GSEL_W'(j);
      end
    end
    hit_slot = {grp_r, grp_sel};
  end

  assign issue_done = (rd_cnt_r == CNT_W'(SLOTS));
  assign life_dec   = life_rd_data - LIFE_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r       <= res_nxt;
    life_r      <= life_nxt;
    grp_r       <= grp_nxt;
    rd_cnt_r    <= rd_cnt_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    res_nxt       = res_r;
    life_nxt      = life_r;
    grp_nxt       = grp_r;
    rd_cnt_nxt    = rd_cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    life_wr       = '0;
    life_rd       = '0;
    req_stall     = 1'b1;
    res_valid     = 1'b0;

    case (state_r)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          res_nxt = '{status: ST_OK, granted_slot: '0, freed_count: '0};
          case (req.operation)
            OP_ALLOC: begin
              life_nxt  = req.lifetime;
              grp_nxt   = '0;
              state_nxt = S_SCAN;
            end
            OP_TICK: begin
              rd_cnt_nxt = '0;
              state_nxt  = S_TICK;
            end
            OP_DELETE: begin
              if (int'(req.slot_index) < SLOTS &&
                  used_r[SLOT_W'(req.slot_index)]) begin
                used_nxt[SLOT_W'(req.slot_index)] = 1'b0;
              end else begin
                res_nxt.status = ST_NOT_USED;
              end
              state_nxt = S_PUT;
            end
            OP_CLEAR: begin
              used_nxt  = '0;
              state_nxt = S_PUT;
            end
            default: state_nxt = S_PUT;
          endcase
        end
      end

      S_SCAN: begin
        if (grp_hit) begin
          used_nxt[hit_slot]   = 1'b1;
          life_wr.en           = 1'b1;
          life_wr.addr         = hit_slot;
          life_wr.data         = life_r;
          res_nxt.granted_slot = GRANT_W'(hit_slot);
          state_nxt            = S_PUT;
        end else if (grp_r == GROUP_W'(GROUPS - 1)) begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_PUT;
        end else begin
          grp_nxt = grp_r + GROUP_W'(1);
        end
      end

      S_TICK: begin
        // Retire the slot read last cycle.
        if (pend_r && used_r[pend_addr_r] && life_rd_data != '0) begin
          life_wr.en   = 1'b1;
          life_wr.addr = pend_addr_r;
          life_wr.data = life_dec;
          if (life_dec == '0) begin
            used_nxt[pend_addr_r] = 1'b0;
            res_nxt.freed_count   = res_r.freed_count + FREED_W'(1);
          end
        end
        // Issue the next read.
        if (!issue_done) begin
          life_rd.en    = 1'b1;
          life_rd.addr  = rd_cnt_r[SLOT_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_cnt_r[SLOT_W-1:0];
          rd_cnt_nxt    = rd_cnt_r + CNT_W'(1);
        end else if (pend_r) begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign res = res_r;

  // Lifetime memory is written only by allocate and tick.
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    life_wr.en |-> (state_r == S_SCAN || state_r == S_TICK))
    else $error("lifetime write outside allocate or tick");

  // The retiring slot trails the read pointer by exactly one entry.
  a_pend_lag: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ({1'b0, pend_addr_r} + CNT_W'(1) == rd_cnt_r))
    else $error("tick read pipeline out of step");

  // A granted slot is marked used when the result appears.
  a_grant_used: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_SCAN && state_r == S_PUT && res_r.status == ST_OK)
      |-> used_r[SLOT_W'(res_r.granted_slot)])
    else $error("granted slot not marked used");

  // A tick cannot free more slots than the pool holds.
  a_freed_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |-> (int'(res_r.freed_count) <= SLOTS))
    else $error("freed count exceeds pool size");

endmodule

`default_nettype wire

@@ tb/sv/tb_slot_pool_with_lifetime_expiry_top.sv @@
// Self-checking testbench for slot_pool_with_lifetime_expiry_top: directed and random items,
// checked against an in-bench model of the slot pool. Depends on slotpool_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_slot_pool_with_lifetime_expiry_top;
  import slotpool_pkg::*;

  // The quiet limit sits well above a tick's walk through every slot and above
  // a receiver hold-off.
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 2000;
  localparam int TAIL_CYCLES = 200;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 375;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  // Items waiting to be offered, and results owed by the block, oldest first.
  req_t req_pending_q[$];
  rsp_t rsp_due_q[$];

  // Model copy of the pool.
  logic              slot_busy [SLOTS];
  logic [LIFE_W-1:0] slot_ttl  [SLOTS];

  // Idling controls, written by the stimulus process at the falling edge.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;

  // Hold-off bookkeeping, owned by the receiver process.
  int hold_served = 0;
  int hold_left = 0;

  int items_queued = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int tick_count = 0;
  int full_count = 0;
  int expired_total = 0;
  rsp_t rsp_want;

  slot_pool_with_lifetime_expiry_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one operation to the model pool and return the result it owes.
  function automatic rsp_t apply_pool_op(req_t item);
    rsp_t res;
    int   lowest_free;
    int   freed;
    int   s;
    res = '0;
    res.status = ST_OK;
    freed = 0;
    case (item.operation)
      OP_ALLOC: begin
        // Scan downward so the last hit is the lowest free slot.
        lowest_free = -1;
        for (s = SLOTS - 1; s >= 0; s--) begin
          if (!slot_busy[s]) lowest_free = s;
        end
        if (lowest_free < 0) begin
          res.status = ST_FULL;
          full_count++;
        end else begin
          slot_busy[lowest_free] = 1'b1;
          slot_ttl[lowest_free] = item.lifetime;
          res.granted_slot = GRANT_W'(lowest_free);
        end
      end
      OP_TICK: begin
        // A stored lifetime of zero never counts down.
        tick_count++;
        for (s = 0; s < SLOTS; s++) begin
          if (slot_busy[s] && slot_ttl[s] != '0) begin
            slot_ttl[s] = slot_ttl[s] - 1'b1;
            if (slot_ttl[s] == '0) begin
              slot_busy[s] = 1'b0;
              freed++;
            end
          end
        end
        res.freed_count = FREED_W'(freed);
        expired_total += freed;
      end
      OP_DELETE: begin
        if (slot_busy[item.slot_index]) slot_busy[item.slot_index] = 1'b0;
        else res.status = ST_NOT_USED;
      end
      OP_CLEAR: begin
        for (s = 0; s < SLOTS; s++) slot_busy[s] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void push_item(op_t op, logic [LIFE_W-1:0] life,
                                    logic [INDEX_W-1:0] idx);
    req_t item;
    item.operation = op;
    item.lifetime = life;
    item.slot_index = idx;
    req_pending_q = {req_pending_q, item};
    items_queued++;
  endfunction

  // Queue one operation with random fields. Allocate lifetimes lean small so
  // ticks free slots often; delete indexes lean low, where allocate lands.
  function automatic void push_op(op_t op);
    logic [LIFE_W-1:0]  life;
    logic [INDEX_W-1:0] idx;
    int                 pick;
    life = LIFE_W'($urandom);
    idx = INDEX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (op == OP_ALLOC) begin
      if (pick < 25) life = '0;
      else if (pick < 65) life = LIFE_W'($urandom_range(1, 4));
      else if (pick < 85) life = LIFE_W'($urandom_range(5, 40));
      else if (pick < 95) life = LIFE_W'($urandom);
      else life = '1;
    end
    if (op == OP_DELETE && pick < 60) idx = INDEX_W'($urandom_range(0, 15));
    push_item(op, life, idx);
  endfunction

  // Run the pool past full. The forced form uses lifetime one everywhere so
  // the following tick frees the whole pool at once.
  function automatic void gen_fill(bit forced);
    int n;
    int k;
    n = SLOTS + $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      if (forced) push_item(OP_ALLOC, LIFE_W'(1), INDEX_W'($urandom));
      else push_op(OP_ALLOC);
    end
    if (!forced) begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) push_op(OP_DELETE);
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) push_op(OP_ALLOC);
    end
    n = $urandom_range(1, 3);
    for (k = 0; k < n; k++) push_op(OP_TICK);
    if ($urandom_range(0, 1) == 1) push_op(OP_CLEAR);
  endfunction

  function automatic void gen_segment();
    int kind;
    int n;
    int k;
    int pick;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      gen_fill(1'b0);
    end else if (kind < 28) begin
      // Short-lived allocates followed by ticks: drive expiry.
      n = $urandom_range(4, 12);
      for (k = 0; k < n; k++)
        push_item(OP_ALLOC, LIFE_W'($urandom_range(1, 3)), INDEX_W'($urandom));
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) push_op(OP_TICK);
    end else if (kind < 38) begin
      // Noise: any operation, clear as likely as the rest.
      n = $urandom_range(5, 15);
      for (k = 0; k < n; k++) push_op(op_t'($urandom_range(0, 3)));
    end else begin
      for (k = 0; k < 20; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) push_op(OP_ALLOC);
        else if (pick < 67) push_op(OP_TICK);
        else if (pick < 97) push_op(OP_DELETE);
        else push_op(OP_CLEAR);
      end
    end
  endfunction

  // Hold the stimulus until every queued item is taken and every result is in.
  task automatic wait_drain();
    do @(negedge clk);
    while (req_pending_q.size() != 0 || in_valid || rsp_due_q.size() != 0);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, bit lead_fill);
    int start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_queued;
    if (lead_fill) gen_fill(1'b1);
    while (items_queued - start < PHASE_ITEMS) gen_segment();
    wait_drain();
  endtask

  // Driver: predict each accepted item, then offer the next one or idle.
  // A stalled item stays on the bus unchanged.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rsp_due_q = {rsp_due_q, apply_pool_op(in_data)};
        req_pending_q.delete(0);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (req_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= req_pending_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest one owed, then
  // pick the stall for the next cycle. A hold-off request raises stall for a
  // long stretch regardless of the random rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (rsp_due_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: status %0d slot %0d freed %0d",
                     out_data.status, out_data.granted_slot, out_data.freed_count);
        end else begin
          rsp_want = rsp_due_q.pop_front();
          if (out_data.status !== rsp_want.status ||
              out_data.granted_slot !== rsp_want.granted_slot ||
              out_data.freed_count !== rsp_want.freed_count) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("result %0d mismatch: status %0d/%0d slot %0d/%0d freed %0d/%0d (exp/act)",
                       results_seen, rsp_want.status, out_data.status,
                       rsp_want.granted_slot, out_data.granted_slot,
                       rsp_want.freed_count, out_data.freed_count);
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if neither channel moves an item for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("no handshake for %0d cycles", QUIET_LIMIT);
    $display("tb_slot_pool_with_lifetime_expiry_top NOT OK");
    $finish;
  end

  // Stimulus: reset, a directed pass, then four random phases with different idling.
  // This process makes all its queue and control updates at the falling edge.
  initial begin : stimulus
    int s;
    for (s = 0; s < SLOTS; s++) begin
      slot_busy[s] = 1'b0;
      slot_ttl[s] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: lifetime extremes, expiry order, never-expiring slots, delete
    // of used and free slots, lowest-free reuse, tick on an empty pool, clear,
    // and ignored fields set to all ones.
    push_item(OP_ALLOC,  16'h0000, 7'h00);
    push_item(OP_ALLOC,  16'h0001, 7'h7F);
    push_item(OP_ALLOC,  16'hFFFF, 7'h00);
    push_item(OP_ALLOC,  16'h0002, 7'h55);
    push_item(OP_TICK,   16'h0000, 7'h00);
    push_item(OP_TICK,   16'hFFFF, 7'h7F);
    push_item(OP_TICK,   16'h0000, 7'h00);
    push_item(OP_DELETE, 16'h0000, 7'h02);
    push_item(OP_DELETE, 16'hFFFF, 7'h02);
    push_item(OP_DELETE, 16'h0000, 7'h7F);
    push_item(OP_ALLOC,  16'h0005, 7'h00);
    push_item(OP_DELETE, 16'h0000, 7'h00);
    push_item(OP_CLEAR,  16'h0000, 7'h00);
    push_item(OP_TICK,   16'h0000, 7'h00);
    push_item(OP_DELETE, 16'h0000, 7'h00);
    push_item(OP_ALLOC,  16'h0001, 7'h00);
    push_item(OP_ALLOC,  16'h0001, 7'h00);
    push_item(OP_TICK,   16'h0000, 7'h00);
    push_item(OP_ALLOC,  16'h8000, 7'h7F);
    push_item(OP_TICK,   16'hFFFF, 7'h7F);
    push_item(OP_CLEAR,  16'hFFFF, 7'h7F);
    push_item(OP_DELETE, 16'hFFFF, 7'h00);
    wait_drain();

    // No idling, opened by a long receiver hold-off while items keep coming,
    // so the block backs up and stalls its input. Lead with a full pool that
    // one tick empties.
    hold_requests++;
    run_phase(0, 0, 1'b1);
    run_phase(88, 0, 1'b0);
    run_phase(0, 88, 1'b0);
    run_phase(31, 31, 1'b0);

    // Let any stray result surface before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d items: %0d ticks freeing %0d slots, %0d allocates on a full pool",
             items_accepted, tick_count, expired_total, full_count);
    $display("checked %0d results, %0d mismatches, %0d still owed",
             results_seen, mismatch_count, rsp_due_q.size());
    if (mismatch_count == 0 && rsp_due_q.size() == 0) begin
      $display("tb_slot_pool_with_lifetime_expiry_top OK");
    end else begin
      $display("tb_slot_pool_with_lifetime_expiry_top NOT OK");
    end
    $finish;
  end

endmodule
